// ===== sv/bd_pkg.sv =====
// Shared types, sizes and helpers for the bounded deque.
package bd_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // result queue at the output
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_DUMP      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } result_t;

    // ring position of a sum below 2*DEPTH
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] s);
        logic [CNT_W:0] t;
        t = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
        return t[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/bd_front.sv =====
// Front end: accepts words, drops undefined ops, queues commands for the back end.
module bd_front import bd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_pop
);

    cmd_t                cq_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                accept;
    logic                enq;

    localparam logic [CQ_CNT_W-1:0] CQ_FULL = CQ_CNT_W'(CQ_DEPTH);
    localparam logic [CQ_PTR_W-1:0] CQ_LAST = CQ_PTR_W'(CQ_DEPTH - 1);

    assign full      = (count_reg == CQ_FULL);
    assign accept    = push && !full;
    assign enq       = accept && (op <= OP_DUMP);  // codes past dump are dropped
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cq_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_LAST) ? '0 : wr_ptr_reg + CQ_PTR_W'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_LAST) ? '0 : rd_ptr_reg + CQ_PTR_W'(1);
        end
        if (enq && !cmd_pop)
        begin
            count_next = count_reg + CQ_CNT_W'(1);
        end
        else if (!enq && cmd_pop)
        begin
            count_next = count_reg - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            cq_mem[wr_ptr_reg] <= '{op: op_t'(op), value: value};
        end
    end

endmodule

// ===== sv/bd_back.sv =====
// Back end: deque state, ring store and dump sequencer.
module bd_back import bd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    input  logic [OQ_CNT_W-1:0] oq_count,
    output logic                res_push,
    output result_t             res
);

    typedef enum logic {S_IDLE, S_DUMP} state_t;

    localparam logic [OQ_CNT_W:0] OQ_SLOTS = (OQ_CNT_W + 1)'(OQ_DEPTH);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic               resb_valid_reg, resb_valid_next;
    status_t            resb_status_reg, resb_status_next;
    logic               resb_last_reg, resb_last_next;
    logic               resb_mem_reg, resb_mem_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W:0]     front_x;
    logic [CNT_W-1:0]   dcnt_inc;
    logic               room;
    logic               is_full;
    logic               is_empty;

    // one slot kept for the word already in the result stage
    assign room     = (({1'b0, oq_count} + (OQ_CNT_W + 1)'(resb_valid_reg)) < OQ_SLOTS);
    assign is_full  = (fill_reg == FILL_MAX);
    assign is_empty = (fill_reg == '0);
    assign front_x  = (CNT_W + 1)'(front_reg);
    assign dcnt_inc = dcnt_reg + CNT_W'(1);
    assign rd_addr  = ring_wrap(front_x + {1'b0, dcnt_reg});
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid && room;

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        fill_next        = fill_reg;
        dcnt_next        = dcnt_reg;
        resb_valid_next  = 1'b0;
        resb_status_next = ST_OK;
        resb_last_next   = 1'b1;
        resb_mem_next    = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = ring_wrap(front_x + {1'b0, fill_reg});

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    unique case (cmd.op)
                        OP_INS_FRONT:
                        begin
                            resb_valid_next = 1'b1;
                            if (is_full)
                            begin
                                resb_status_next = ST_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? LAST_IDX
                                                               : front_reg - IDX_W'(1);
                                wr_addr    = front_next;
                                wr_en      = 1'b1;
                                fill_next  = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_INS_BACK:
                        begin
                            resb_valid_next = 1'b1;
                            if (is_full)
                            begin
                                resb_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT:
                        begin
                            resb_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                resb_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_wrap(front_x + (CNT_W + 1)'(1));
                                fill_next  = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_DEL_BACK:
                        begin
                            resb_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                resb_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                resb_valid_next  = 1'b1;
                                resb_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                dcnt_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // read issued now, data lands with the result stage
                if (room)
                begin
                    resb_valid_next = 1'b1;
                    resb_mem_next   = 1'b1;
                    resb_last_next  = (dcnt_inc == fill_reg);
                    dcnt_next       = dcnt_inc;
                    if (dcnt_inc == fill_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            front_reg       <= '0;
            fill_reg        <= '0;
            dcnt_reg        <= '0;
            resb_valid_reg  <= 1'b0;
            resb_status_reg <= ST_OK;
            resb_last_reg   <= 1'b0;
            resb_mem_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            fill_reg        <= fill_next;
            dcnt_reg        <= dcnt_next;
            resb_valid_reg  <= resb_valid_next;
            resb_status_reg <= resb_status_next;
            resb_last_reg   <= resb_last_next;
            resb_mem_reg    <= resb_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign res_push    = resb_valid_reg;
    assign res.status  = resb_status_reg;
    assign res.element = resb_mem_reg ? rd_data_reg : '0;
    assign res.last    = resb_last_reg;

endmodule

// ===== sv/bd_outq.sv =====
// Result queue: holds finished words until the consumer pops them.
module bd_outq import bd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_push,
    input  result_t             res,
    input  logic                pop,
    output logic                empty,
    output result_t             head,
    output logic [OQ_CNT_W-1:0] count
);

    localparam logic [OQ_PTR_W-1:0] OQ_LAST = OQ_PTR_W'(OQ_DEPTH - 1);

    result_t             oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic                deq;

    assign empty = (count_reg == '0);
    assign deq   = pop && !empty;
    assign head  = oq_mem[rd_ptr_reg];
    assign count = count_reg;

    // back end only pushes when a slot is reserved
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == OQ_LAST) ? '0 : wr_ptr_reg + OQ_PTR_W'(1);
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == OQ_LAST) ? '0 : rd_ptr_reg + OQ_PTR_W'(1);
        end
        if (res_push && !deq)
        begin
            count_next = count_reg + OQ_CNT_W'(1);
        end
        else if (!res_push && deq)
        begin
            count_next = count_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            oq_mem[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== sv/bounded_deque.sv =====
// Bounded double-ended queue of signed 32-bit words: top level.
// A result passes the command queue, the back end's result stage and the result queue;
//   the back end takes the next insert or delete while earlier results are in flight.
// A dump holds the back end and reads one stored element per cycle while the result
//   queue has room, as the store has a single read port; an empty dump gives one result.
// Reset clears queue pointers, fill count and the dump sequencer; store contents stay.
module bounded_deque import bd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command side
    input  logic               push,
    output logic               full,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic signed [31:0] element,
    output logic               last
);

    // front -> back command queue head
    logic                cmd_valid;
    cmd_t                cmd;
    logic                cmd_pop;

    // back -> result queue
    logic                res_push;
    result_t             res;
    logic [OQ_CNT_W-1:0] oq_count;
    result_t             head;

    // Front end: takes a word whenever its two-entry queue has room, and
    // silently drops undefined op codes so they produce no result.
    bd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: owns front index, fill count and the ring store. It only
    // starts work when the result queue has a free slot, counting the word
    // already in its result stage, so nothing is ever lost downstream.
    bd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .oq_count (oq_count),
        .res_push (res_push),
        .res      (res)
    );

    // Result queue: decouples the consumer's pop from the back end.
    bd_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .pop      (pop),
        .empty    (empty),
        .head     (head),
        .count    (oq_count)
    );

    assign status  = head.status;
    assign element = head.element;
    assign last    = head.last;

endmodule

// ===== sv/bd_checker.sv =====
// Port-level checker for the bounded deque, bound to the top level.
module bd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         status,
    input logic signed [31:0] element,
    input logic               last
);

    localparam logic [1:0] CK_OK   = 2'd0;
    localparam logic [1:0] CK_FULL = 2'd2;

    // no status code past "full"
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == CK_OK || status != 2'd3))
        else $error("bad status code");

    // an error status always closes its word's results
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != CK_OK) |-> last)
        else $error("error result without last");

    // results with an error status carry no element
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != CK_OK || status == CK_FULL)) |-> (element == '0))
        else $error("error result with nonzero element");

    // a waiting result holds while not popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(element)
                              && $stable(last)))
        else $error("result changed while stalled");

endmodule

bind bounded_deque bd_checker u_bd_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop     (pop),
    .status  (status),
    .element (element),
    .last    (last)
);
